// ===== rtl/cic_pkg.sv =====
// ----------------------------------------------------------------------------
// CIC decimator package
// Shared widths, register indexes and sequencer state codes.
// ----------------------------------------------------------------------------
`default_nettype none

package cic_pkg;

    localparam int ACC_W    = 32;
    localparam int SAMPLE_W = 16;
    localparam int OUT_W    = 16;
    localparam int ORDER_W  = 4;
    localparam int FACTOR_W = 11;
    localparam int SHIFT_W  = 5;
    localparam int CFG_W    = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] REG_ORDER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FACTOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_INTEG = 4'b0010,
        ST_COMB  = 4'b0100,
        ST_OUT   = 4'b1000
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/cic_shclamp.sv =====
// ----------------------------------------------------------------------------
// CIC output shift and clamp
// Right shift of the comb result, then clamp to 0..65535 (negative values give 0).
// ----------------------------------------------------------------------------
`default_nettype none

module cic_shclamp (
    input  wire logic [cic_pkg::ACC_W-1:0]   i_value,
    input  wire logic [cic_pkg::SHIFT_W-1:0] i_shift,
    output logic      [cic_pkg::OUT_W-1:0]   o_result
);
    import cic_pkg::*;

    logic [ACC_W-1:0] shifted;

    always_comb begin
        shifted = i_value >> i_shift;
        if (i_value[ACC_W-1]) begin
            o_result = '0;
        end else if (|shifted[ACC_W-1:OUT_W]) begin
            o_result = OUT_MAX;
        end else begin
            o_result = shifted[OUT_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cic_decimator.sv =====
// ----------------------------------------------------------------------------
// CIC decimator
// Cascaded integrator-comb decimation filter with a shared 32-bit adder.
// ----------------------------------------------------------------------------
// Each accepted sample runs through the active integrator stages one stage
// per cycle on a single shared 32-bit add/subtract unit (stages in use: the
// filter order, at most MAX_ORDER). On an output phase the comb stages follow
// on the same unit, and the result is then loaded into the output register
// once that register is free. The block takes no new sample while a sample is
// in work, but it takes one while a finished result waits on the output.
// Registers (index: field): 0 filter order, 1 decimation factor (a write
// restarts the phase count), 2 attenuation shift. Write only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module cic_decimator #(
    parameter int MAX_ORDER = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [cic_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [cic_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [15:0]                   s_axis_tdata,  // [15:0] sample
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic      [15:0]                   m_axis_tdata   // [15:0] filtered
);
    import cic_pkg::*;

    localparam int IDX_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int ST_W  = $clog2(MAX_ORDER + 1);

    t_state                  r_state, n_state;
    logic [ORDER_W-1:0]      r_order;
    logic [FACTOR_W-1:0]     r_factor;
    logic [SHIFT_W-1:0]      r_shift;
    logic [FACTOR_W-1:0]     r_phase;
    logic                    r_emit;
    logic [IDX_W-1:0]        r_k;
    logic [ACC_W-1:0]        r_x;
    logic [ACC_W-1:0]        r_acc [MAX_ORDER];
    logic [ACC_W-1:0]        r_dly [MAX_ORDER];
    logic                    r_out_valid;
    logic [OUT_W-1:0]        r_out;

    logic [ST_W-1:0]         stages;
    logic                    last_stage;
    logic                    in_fire;
    logic                    out_load;
    logic [ACC_W-1:0]        op_a, op_b, sum;
    logic                    op_sub;
    logic [OUT_W-1:0]        clamped;
    logic [FACTOR_W-1:0]     factor_eff;

    assign stages = (int'(r_order) > MAX_ORDER) ? ST_W'(MAX_ORDER) : ST_W'(r_order);
    assign last_stage = ((ST_W'(r_k) + ST_W'(1)) == stages);
    assign factor_eff = (r_factor == '0) ? FACTOR_W'(1) : r_factor;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_load      = (r_state == ST_OUT) && (!r_out_valid || m_axis_tready);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    // shared add/subtract unit
    always_comb begin
        op_sub = (r_state == ST_COMB);
        op_a   = op_sub ? r_x : r_acc[r_k];
        op_b   = op_sub ? ~r_dly[r_k] : r_x;
        sum    = op_a + op_b + ACC_W'(op_sub);
    end

    cic_shclamp u_shclamp (
        .i_value  (r_x),
        .i_shift  (r_shift),
        .o_result (clamped)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (stages != '0) begin
                        n_state = ST_INTEG;
                    end else if (r_phase <= FACTOR_W'(1)) begin
                        n_state = ST_OUT;
                    end
                end
            end
            ST_INTEG: begin
                if (last_stage) begin
                    n_state = r_emit ? ST_COMB : ST_IDLE;
                end
            end
            ST_COMB: begin
                if (last_stage) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_order     <= ORDER_W'(1);
            r_factor    <= FACTOR_W'(1);
            r_shift     <= '0;
            r_phase     <= FACTOR_W'(1);
            r_emit      <= 1'b0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MAX_ORDER; i++) begin
                r_acc[i] <= '0;
                r_dly[i] <= '0;
            end
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_ORDER:  r_order  <= i_cfg_data[ORDER_W-1:0];
                    REG_FACTOR: begin
                        r_factor <= i_cfg_data[FACTOR_W-1:0];
                        r_phase  <= (i_cfg_data[FACTOR_W-1:0] == '0) ?
                                    FACTOR_W'(1) : i_cfg_data[FACTOR_W-1:0];
                    end
                    REG_SHIFT:  r_shift  <= i_cfg_data[SHIFT_W-1:0];
                    default: ;
                endcase
            end

            if (in_fire) begin
                r_k <= '0;
                if (r_phase > FACTOR_W'(1)) begin
                    r_phase <= r_phase - FACTOR_W'(1);
                    r_emit  <= 1'b0;
                end else begin
                    r_phase <= factor_eff;
                    r_emit  <= 1'b1;
                end
            end

            if (r_state == ST_INTEG) begin
                r_acc[r_k] <= sum;
                r_k        <= last_stage ? '0 : r_k + IDX_W'(1);
            end

            if (r_state == ST_COMB) begin
                r_dly[r_k] <= r_x;
                r_k        <= last_stage ? '0 : r_k + IDX_W'(1);
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_x <= ACC_W'(s_axis_tdata);
        end else if (r_state == ST_INTEG || r_state == ST_COMB) begin
            r_x <= sum;
        end
        if (out_load) begin
            r_out <= clamped;
        end
    end

    a_comb_only_on_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COMB) |-> r_emit)
        else $error("comb pass without output phase");

    a_stage_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INTEG || r_state == ST_COMB) |-> (ST_W'(r_k) < stages))
        else $error("stage index beyond stages in use");

    a_phase_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != '0)
        else $error("phase count reached zero");

    a_valid_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == ST_OUT))
        else $error("result shown without output step");

endmodule

`default_nettype wire
